/* rtl/brk_pkg.sv */
// shared types, constants and helpers for the bit vector rank engine
package brk_pkg;

  localparam int WORD_W  = 64;
  localparam int INDEX_W = 10;
  localparam int POS_W   = 16;
  localparam int RANK_W  = 17;
  localparam int WORDS_W = 12;
  localparam int PCNT_W  = 7;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_RANK  = 1'b1;

  typedef enum logic [1:0] {
    REQ_WRITE,
    REQ_QUERY,
    REQ_ZERO
  } req_kind_t;

  typedef struct packed {
    req_kind_t           kind;
    logic [INDEX_W-1:0]  word_addr;
    logic [WORD_W-1:0]   word_value;
    logic [POS_W-1:0]    position;
  } req_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_REBUILD,
    B_COUNT,
    B_SUM
  } back_state_t;

  // adder tree: nibble counts, then groups of four, then the final four
  function automatic logic [PCNT_W-1:0] popcount64(input logic [WORD_W-1:0] x);
    logic [2:0] c4 [16];
    logic [4:0] c16 [4];
    for (int i = 0; i < 16; i++) begin
      c4[i] = 3'(x[4*i]) + 3'(x[4*i+1]) + 3'(x[4*i+2]) + 3'(x[4*i+3]);
    end
    for (int j = 0; j < 4; j++) begin
      c16[j] = 5'(c4[4*j]) + 5'(c4[4*j+1]) + 5'(c4[4*j+2]) + 5'(c4[4*j+3]);
    end
    return (PCNT_W'(c16[0]) + PCNT_W'(c16[1])) + (PCNT_W'(c16[2]) + PCNT_W'(c16[3]));
  endfunction

endpackage

/* rtl/brk_front.sv */
// front end: takes requests, drops out-of-range writes, clamps rank positions
module brk_front
  import brk_pkg::*;
(
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               op,
  input  logic [INDEX_W-1:0] word_addr,
  input  logic [WORD_W-1:0]  word_value,
  input  logic [POS_W-1:0]   position,
  input  logic [RANK_W-1:0]  bits_used,
  input  logic [WORDS_W-1:0] words_used,
  input  logic               q_full,
  output logic               push,
  output req_t               push_req
);

  logic              accept;
  logic              in_range;
  logic [RANK_W-1:0] last_bit;
  logic [POS_W-1:0]  pos_clamped;

  assign item_stall = q_full;
  assign accept     = item_valid && !q_full;
  assign in_range   = WORDS_W'(word_addr) < words_used;
  assign last_bit   = bits_used - RANK_W'(1);

  always_comb begin
    if (RANK_W'(position) >= bits_used) begin
      pos_clamped = last_bit[POS_W-1:0];
    end else begin
      pos_clamped = position;
    end
  end

  always_comb begin
    push_req.word_addr  = word_addr;
    push_req.word_value = word_value;
    push_req.position   = pos_clamped;
    push                = 1'b0;
    if (op == OP_WRITE) begin
      push_req.kind = REQ_WRITE;
      push          = accept && in_range;
    end else begin
      // empty vector answers zero without touching the directory
      push_req.kind = (bits_used == '0) ? REQ_ZERO : REQ_QUERY;
      push          = accept;
    end
  end

endmodule

/* rtl/brk_queue.sv */
// two-entry request queue between front and back
module brk_queue
  import brk_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  req_t push_req,
  output logic full,
  input  logic pop,
  output logic empty,
  output req_t head
);

  req_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_req;
    end
  end

endmodule

/* rtl/brk_back.sv */
// back end: word store, rank directory, rebuild walk and rank lookup
module brk_back
  import brk_pkg::*;
#(
  parameter int MAX_WORDS       = 1024,
  parameter int WORDS_PER_SUPER = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [WORDS_W-1:0] words_used,
  input  logic               empty,
  input  req_t               head,
  output logic               pop,
  output logic               rank_valid,
  input  logic               rank_stall,
  output logic [RANK_W-1:0]  rank
);

  localparam int AW     = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int CW     = $clog2(MAX_WORDS + 1);
  localparam int SD     = (MAX_WORDS + WORDS_PER_SUPER - 1) / WORDS_PER_SUPER;
  localparam int SAW    = (SD > 1) ? $clog2(SD) : 1;
  localparam int DW     = $clog2(WORDS_PER_SUPER);
  localparam int REL_W  = $clog2(WORDS_PER_SUPER * 64);
  localparam int MUL_S  = AW + DW;
  localparam int RW     = MUL_S + 1;
  localparam logic [63:0] RECIP =
    ((64'd1 << MUL_S) + WORDS_PER_SUPER - 1) / WORDS_PER_SUPER;

  back_state_t state, state_next;

  logic [WORD_W-1:0] word_mem [MAX_WORDS];
  logic [REL_W-1:0]  wcnt_mem [MAX_WORDS];
  logic [RANK_W-1:0] scnt_mem [SD];

  logic [WORD_W-1:0] word_rd;
  logic [REL_W-1:0]  wc_rd;
  logic [RANK_W-1:0] sc_rd;

  logic              stale;
  logic [CW-1:0]     n_words;
  logic [AW-1:0]     last_word;
  logic [AW-1:0]     qwi;
  logic [AW-1:0]     wr_addr;
  logic [AW-1:0]     raddr;
  logic [SAW-1:0]    qsidx;
  logic [AW+RW-1:0]  prod;

  // rebuild pipeline
  logic [CW-1:0]     rb_issue;
  logic              rb_issuing;
  logic              v1, v2;
  logic [AW-1:0]     i1, i2;
  logic [PCNT_W-1:0] pc2;
  logic [DW-1:0]     sp;
  logic [SAW-1:0]    sidx;
  logic [REL_W-1:0]  rel, rel_base;
  logic [RANK_W-1:0] total;
  logic              first;
  logic              wc_we, sc_we;
  logic              rb_done;
  logic              rb_start;

  // lookup
  logic [RANK_W-1:0] base;
  logic [PCNT_W-1:0] qpc;
  logic [WORD_W-1:0] mask;

  logic              mem_we;
  logic              out_free;
  logic              load_out;
  logic [RANK_W-1:0] out_value;

  // width adaptation between the fixed port fields and the store address
  logic [AW+INDEX_W-1:0] qwide, wwide;
  logic [CW+WORDS_W-1:0] nwide;

  assign qwide   = {AW'(0), head.position[POS_W-1:6]};
  assign wwide   = {AW'(0), head.word_addr};
  assign nwide   = {CW'(0), words_used};
  assign qwi     = qwide[AW-1:0];
  assign wr_addr = wwide[AW-1:0];
  assign n_words = nwide[CW-1:0];
  assign last_word = AW'(n_words - CW'(1));

  // superblock of the queried word by reciprocal multiply
  assign prod  = {RW'(0), qwi} * {AW'(0), RECIP[RW-1:0]};
  assign qsidx = prod[MUL_S +: SAW];

  assign raddr      = (state == B_REBUILD) ? rb_issue[AW-1:0] : qwi;
  assign rb_issuing = (state == B_REBUILD) && (rb_issue < n_words);

  assign first    = (sp == '0);
  assign rel_base = first ? '0 : rel;
  assign wc_we    = (state == B_REBUILD) && v2;
  assign sc_we    = wc_we && first;
  assign rb_done  = wc_we && (i2 == last_word);

  assign mask     = {WORD_W{1'b1}} >> (6'd63 - head.position[5:0]);
  assign out_free = !rank_valid || !rank_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    mem_we     = 1'b0;
    load_out   = 1'b0;
    out_value  = '0;
    rb_start   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (!empty) begin
          unique case (head.kind)
            REQ_WRITE: begin
              mem_we = 1'b1;
              pop    = 1'b1;
            end
            REQ_ZERO: begin
              if (out_free) begin
                load_out = 1'b1;
                pop      = 1'b1;
              end
            end
            REQ_QUERY: begin
              if (stale) begin
                rb_start   = 1'b1;
                state_next = B_REBUILD;
              end else begin
                state_next = B_COUNT;
              end
            end
            default: begin
              pop = 1'b1;
            end
          endcase
        end
      end
      B_REBUILD: begin
        if (rb_done) begin
          state_next = B_IDLE;
        end
      end
      B_COUNT: begin
        state_next = B_SUM;
      end
      B_SUM: begin
        if (out_free) begin
          load_out   = 1'b1;
          out_value  = base + RANK_W'(qpc);
          pop        = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: begin
        state_next = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale <= 1'b1;
    end else if (cfg_write || mem_we) begin
      stale <= 1'b1;
    end else if (rb_done) begin
      stale <= 1'b0;
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[wr_addr] <= head.word_value;
    end
    word_rd <= word_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (wc_we) begin
      wcnt_mem[i2] <= rel_base;
    end
    wc_rd <= wcnt_mem[qwi];
  end

  always_ff @(posedge clk) begin
    if (sc_we) begin
      scnt_mem[sidx] <= total;
    end
    sc_rd <= scnt_mem[qsidx];
  end

  // rebuild walk: issue read, popcount, accumulate and write counts
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (rb_start) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= rb_issuing;
      v2 <= v1 && (state == B_REBUILD);
    end
  end

  always_ff @(posedge clk) begin
    if (rb_start) begin
      rb_issue <= '0;
      sp       <= '0;
      sidx     <= '0;
      total    <= '0;
    end else begin
      if (rb_issuing) begin
        rb_issue <= rb_issue + CW'(1);
      end
      if (wc_we) begin
        rel   <= rel_base + REL_W'(pc2);
        total <= total + RANK_W'(pc2);
        if (sp == DW'(WORDS_PER_SUPER - 1)) begin
          sp   <= '0;
          sidx <= sidx + SAW'(1);
        end else begin
          sp <= sp + DW'(1);
        end
      end
    end
    i1  <= rb_issue[AW-1:0];
    i2  <= i1;
    pc2 <= popcount64(word_rd);
  end

  // lookup: superblock plus word count, and masked popcount of the queried word
  always_ff @(posedge clk) begin
    if (state == B_COUNT) begin
      base <= sc_rd + RANK_W'(wc_rd);
      qpc  <= popcount64(word_rd & mask);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rank_valid <= 1'b0;
    end else if (load_out) begin
      rank_valid <= 1'b1;
    end else if (!rank_stall) begin
      rank_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rank <= out_value;
    end
  end

endmodule

/* rtl/bitvector_rank_engine.sv */
// rank engine top: takes one request per cycle while the queue has room; in the back
// end a write is stored from the queue head, and a clean rank query reads the store and
// directory, takes the masked popcount and sums; a query after writes or a length change
// first walks all words in use through the single word store read port;
// reset clears control, sets bits in use to 0 and marks the directory stale;
// word store and directory contents are unspecified until written
module bitvector_rank_engine
  import brk_pkg::*;
#(
  parameter int MAX_WORDS       = 1024,
  parameter int WORDS_PER_SUPER = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               bits_in_use_we,
  input  logic [RANK_W-1:0]  bits_in_use,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               op,
  input  logic [INDEX_W-1:0] word_addr,
  input  logic [WORD_W-1:0]  word_value,
  input  logic [POS_W-1:0]   position,
  output logic               rank_valid,
  input  logic               rank_stall,
  output logic [RANK_W-1:0]  rank
);

  localparam logic [31:0] MAX_BITS = 32'(MAX_WORDS * 64);

  logic [RANK_W-1:0]  bits_used, bits_sat;
  logic [WORDS_W-1:0] words_used;
  logic [RANK_W:0]    bits_round;

  logic q_full, q_empty, push, pop;
  req_t push_req, head;

  always_comb begin
    if (32'(bits_in_use) > MAX_BITS) begin
      bits_sat = MAX_BITS[RANK_W-1:0];
    end else begin
      bits_sat = bits_in_use;
    end
  end

  assign bits_round = {1'b0, bits_sat} + (RANK_W+1)'(63);

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_used  <= '0;
      words_used <= '0;
    end else if (bits_in_use_we) begin
      bits_used  <= bits_sat;
      words_used <= bits_round[RANK_W:6];
    end
  end

  brk_front u_front (
    .item_valid (item_valid),
    .item_stall (item_stall),
    .op         (op),
    .word_addr  (word_addr),
    .word_value (word_value),
    .position   (position),
    .bits_used  (bits_used),
    .words_used (words_used),
    .q_full     (q_full),
    .push       (push),
    .push_req   (push_req)
  );

  brk_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  brk_back #(
    .MAX_WORDS       (MAX_WORDS),
    .WORDS_PER_SUPER (WORDS_PER_SUPER)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (bits_in_use_we),
    .words_used (words_used),
    .empty      (q_empty),
    .head       (head),
    .pop        (pop),
    .rank_valid (rank_valid),
    .rank_stall (rank_stall),
    .rank       (rank)
  );

endmodule
